FILE: rtl/utf8_stream_decoder_core_macros.svh
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define U8SD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder check failed");

// Next-cycle implication, checked only out of reset.
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder check failed");

`endif

FILE: rtl/u8sd_pkg.sv
// Types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int unsigned CP_BITS   = 21;
    localparam int unsigned LEN_BITS  = 3;
    localparam int unsigned PEND_BITS = 2;
    localparam int unsigned OUT_CNT_BITS = 16;

    localparam logic [1:0] CONT_TAG = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    localparam logic [LEN_BITS-1:0] LEN_ERR = 3'd0;
    localparam logic [LEN_BITS-1:0] LEN_1   = 3'd1;
    localparam logic [LEN_BITS-1:0] LEN_2   = 3'd2;
    localparam logic [LEN_BITS-1:0] LEN_3   = 3'd3;
    localparam logic [LEN_BITS-1:0] LEN_4   = 3'd4;

    typedef struct packed {
        logic [CP_BITS-1:0]      code_point;
        logic [LEN_BITS-1:0]     seq_bytes;
        logic                    decode_error;
        logic                    end_of_text;
        logic [OUT_CNT_BITS-1:0] points_seen;
    } t_result;

endpackage

FILE: rtl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder top level: byte-serial decode with a two-entry result buffer.
//
// Input channel: one raw byte per word on i_in_byte, handshake i_in_valid / o_in_ready.
// Output channel: one decoded word (code point, sequence length, error flag,
// end-of-text flag, running point count) with o_out_valid / i_out_ready.
// A lead byte taken between sequences, or a continuation byte inside a sequence that does not finish it, gives no word.
// Every other byte gives one word, held in the result buffer in the cycle after it is taken.
// Throughput is one byte per cycle while o_in_ready is high: the per-byte decode is a single combinational
// step from the decoder state registers into the result buffer.
// The result buffer holds two words (output register plus skid), so a byte is
// still taken while one word waits; o_in_ready drops only when both are full,
// i.e. after the receiver has stalled with a further word already pending.
// Reset (synchronous, active low) clears the decoder state, the point count
// and both buffer slots; no word is lost or repeated under any stall pattern.
// The point count is COUNT_BITS wide, saturates, and is shown as its low 16 bits.
`include "utf8_stream_decoder_core_macros.svh"

module utf8_stream_decoder_core #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_seq_bytes,
    output logic        o_decode_error,
    output logic        o_end_of_text,
    output logic [15:0] o_points_seen
);

    logic [u8sd_pkg::PEND_BITS-1:0] r_pending, n_pending;
    logic [u8sd_pkg::CP_BITS-1:0]   r_partial, n_partial;
    logic [u8sd_pkg::LEN_BITS-1:0]  r_length,  n_length;
    logic [COUNT_BITS-1:0]          r_count,   n_count;

    u8sd_pkg::t_result r_out, r_skid, res;
    logic              r_out_valid, r_skid_valid;

    logic                   accept, take, cont, res_valid;
    logic [COUNT_BITS-1:0]  cnt_inc, cnt_shown;
    logic [COUNT_BITS+15:0] cnt_ext;
    logic [u8sd_pkg::PEND_BITS-1:0] pend_dec;

    assign o_in_ready = !r_skid_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign take       = r_out_valid && i_out_ready;

    assign cont     = (i_in_byte[7:6] == u8sd_pkg::CONT_TAG);
    assign cnt_inc  = (r_count == {COUNT_BITS{1'b1}}) ? r_count : r_count + 1'b1;
    assign pend_dec = r_pending - 1'b1;

    // count shown on the word: incremented on success, as gathered on error
    always_comb begin
        cnt_ext = '0;
        cnt_ext[COUNT_BITS-1:0] = cnt_shown;
    end

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        n_length  = r_length;
        n_count   = r_count;
        res_valid = 1'b0;
        cnt_shown = cnt_inc;
        res.code_point   = '0;
        res.seq_bytes    = u8sd_pkg::LEN_ERR;
        res.decode_error = 1'b0;
        res.end_of_text  = 1'b0;
        if (r_pending != '0) begin
            if (!cont) begin
                res_valid        = 1'b1;
                res.decode_error = 1'b1;
                cnt_shown        = r_count;
                n_count          = '0;
                n_pending        = '0;
                n_partial        = '0;
                n_length         = u8sd_pkg::LEN_ERR;
            end else begin
                n_partial = {r_partial[u8sd_pkg::CP_BITS-7:0], i_in_byte[5:0]};
                n_pending = pend_dec;
                if (pend_dec == '0) begin
                    res_valid      = 1'b1;
                    res.code_point = {r_partial[u8sd_pkg::CP_BITS-7:0], i_in_byte[5:0]};
                    res.seq_bytes  = r_length;
                    n_count        = cnt_inc;
                    n_partial      = '0;
                    n_length       = u8sd_pkg::LEN_ERR;
                end
            end
        end else begin
            priority if (i_in_byte == 8'h00) begin
                res_valid       = 1'b1;
                res.seq_bytes   = u8sd_pkg::LEN_1;
                res.end_of_text = 1'b1;
                n_count         = '0;
            end else if (cont || (i_in_byte[7:3] == 5'b11111)) begin
                res_valid        = 1'b1;
                res.decode_error = 1'b1;
                cnt_shown        = r_count;
                n_count          = '0;
                n_partial        = '0;
                n_length         = u8sd_pkg::LEN_ERR;
            end else if (!i_in_byte[7]) begin
                res_valid      = 1'b1;
                res.code_point = {14'd0, i_in_byte[6:0]};
                res.seq_bytes  = u8sd_pkg::LEN_1;
                n_count        = cnt_inc;
            end else if (i_in_byte[7:5] == u8sd_pkg::LEAD2_TAG) begin
                n_length  = u8sd_pkg::LEN_2;
                n_partial = {16'd0, i_in_byte[4:0]};
                n_pending = 2'd1;
            end else if (i_in_byte[7:4] == u8sd_pkg::LEAD3_TAG) begin
                n_length  = u8sd_pkg::LEN_3;
                n_partial = {17'd0, i_in_byte[3:0]};
                n_pending = 2'd2;
            end else begin
                n_length  = u8sd_pkg::LEN_4;
                n_partial = {18'd0, i_in_byte[2:0]};
                n_pending = 2'd3;
            end
        end
        res.points_seen = cnt_ext[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_partial <= '0;
            r_length  <= u8sd_pkg::LEN_ERR;
            r_count   <= '0;
        end else if (accept) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_length  <= n_length;
            r_count   <= n_count;
        end
    end

    // output register plus skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept && res_valid;
                end
            end else if (accept && res_valid) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= res;
            end
        end else if (accept && res_valid) begin
            if (r_out_valid) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_code_point   = r_out.code_point;
    assign o_seq_bytes    = r_out.seq_bytes;
    assign o_decode_error = r_out.decode_error;
    assign o_end_of_text  = r_out.end_of_text;
    assign o_points_seen  = r_out.points_seen;

    `U8SD_ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `U8SD_ASSERT_IMPL(a_err_word_clean, i_clk, i_rst_n, r_out_valid && r_out.decode_error,
        r_out.code_point == '0 && r_out.seq_bytes == u8sd_pkg::LEN_ERR && !r_out.end_of_text)
    `U8SD_ASSERT_IMPL(a_eot_word, i_clk, i_rst_n, r_out_valid && r_out.end_of_text,
        r_out.seq_bytes == u8sd_pkg::LEN_1 && r_out.code_point == '0)
    `U8SD_ASSERT_IMPL(a_pending_len, i_clk, i_rst_n, r_pending != '0,
        r_length >= u8sd_pkg::LEN_2 && {1'b0, r_pending} < r_length)
    `U8SD_ASSERT_NEXT(a_count_clears, i_clk, i_rst_n,
        accept && res_valid && (res.decode_error || res.end_of_text), r_count == '0)

endmodule
